// ===== rtl/ptsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsa_pkg: shared definitions of the aging priority task scheduler
// Sizes, event codes, register indexes, datapath commands and controller
// states used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package ptsa_pkg;

    localparam int TASK_SLOTS      = 32;
    localparam int PRIORITY_LEVELS = 32;
    localparam int ID_W            = $clog2(TASK_SLOTS);
    localparam int LV_W            = $clog2(PRIORITY_LEVELS);
    localparam int CNT_W           = $clog2(TASK_SLOTS + 1);

    localparam logic [LV_W-1:0] TOP_LEVEL     = LV_W'(PRIORITY_LEVELS - 1);
    localparam logic [LV_W-1:0] DEFAULT_LEVEL = LV_W'(PRIORITY_LEVELS / 2 - 1);
    localparam logic [10:0]     SLICE_MAX     = 11'd1023;

    localparam logic [3:0] MODE_ADD     = 4'd0;
    localparam logic [3:0] MODE_REMOVE  = 4'd1;
    localparam logic [3:0] MODE_BLOCK   = 4'd2;
    localparam logic [3:0] MODE_UNBLOCK = 4'd3;
    localparam logic [3:0] MODE_SETPRIO = 4'd4;
    localparam logic [3:0] MODE_SCHED   = 4'd5;
    localparam logic [3:0] MODE_YIELD   = 4'd6;
    localparam logic [3:0] MODE_TICK    = 4'd7;
    localparam logic [3:0] MODE_QUERY   = 4'd8;

    localparam logic [2:0] CFG_AGING_PERIOD = 3'd0;
    localparam logic [2:0] CFG_AGE_LIMIT    = 3'd1;
    localparam logic [2:0] CFG_AGING_BOOST  = 3'd2;
    localparam logic [2:0] CFG_SLICE_BASE   = 3'd3;
    localparam logic [2:0] CFG_SLICE_STEP   = 3'd4;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_FAIL,
        DP_ADD,
        DP_PUSH,
        DP_UNLINK,
        DP_LV_CUR,
        DP_SEL_RUN,
        DP_REMOVE,
        DP_BLOCK,
        DP_UNBLOCK,
        DP_SETPRIO,
        DP_QUERY,
        DP_TICK,
        DP_TIMER,
        DP_SCAN_TOP,
        DP_SCAN_DOWN,
        DP_PICK,
        DP_RUN,
        DP_AGE_INIT,
        DP_LVL_LOAD,
        DP_LVL_NEXT,
        DP_VISIT,
        DP_SET_UP,
        DP_ADV
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] mode;
        logic       used;
        logic       blocked;
        logic       running;
        logic       req_high;
        logic       run_valid;
        logic       slice_zero;
        logic       age_due;
        logic       lv_nonempty;
        logic       lv_is_zero;
        logic       scan_last;
        logic       cnt_zero;
        logic       age_hit;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH_FIN,
        ST_RM,
        ST_RM_FIN,
        ST_BLK,
        ST_BLK_FIN,
        ST_SET_UL,
        ST_SET_WR,
        ST_SCH_REQ,
        ST_SCH_LV,
        ST_SCH_PUSH,
        ST_SCH_TOP,
        ST_SCH_SCAN,
        ST_SCH_UL,
        ST_SCH_RUN,
        ST_TICK_CHK,
        ST_TIMER,
        ST_AGE_START,
        ST_AGE_LVL,
        ST_AGE_CHK,
        ST_AGE_UL,
        ST_AGE_UP,
        ST_AGE_PUSH,
        ST_AGE_ADV,
        ST_DONE
    } ctl_state_t;

endpackage

// ===== rtl/priority_task_scheduler_aging_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_aging_core: aging multilevel priority task scheduler
// A schedule runs a level search that tests one level per cycle from the top
// level down. A tick that starts an aging pass also steps through the levels
// below the top level and each task queued there. One transaction at a time;
// the next start is taken in the cycle after the result strobe. The receiver
// cannot stall the result.
// Reset leaves every slot free, nothing running and registers at defaults.
// ----------------------------------------------------------------------------
module priority_task_scheduler_aging_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  mode,
    input  logic [4:0]  task_id,
    input  logic [5:0]  priority_req,
    output logic        done,
    output logic        status,
    output logic        running_valid,
    output logic [4:0]  running_task,
    output logic        switched,
    output logic [4:0]  task_priority,
    output logic [9:0]  task_slice,
    output logic [31:0] ctx_switch_count,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ptsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ptsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ptsa_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .mode             (mode),
        .task_id          (task_id),
        .priority_req     (priority_req),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .status           (status),
        .running_valid    (running_valid),
        .running_task     (running_task),
        .switched         (switched),
        .task_priority    (task_priority),
        .task_slice       (task_slice),
        .ctx_switch_count (ctx_switch_count)
    );

endmodule

// ===== rtl/ptsa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsa_datapath: task tables, ready lists and scheduler registers
// Holds the per-task tables and the per-level linked lists, and carries out
// one command from the controller in each cycle.
// ----------------------------------------------------------------------------
module ptsa_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ptsa_pkg::dp_cmd_t         cmd,
    output ptsa_pkg::dp_stat_t        stat,
    input  logic [3:0]                mode,
    input  logic [4:0]                task_id,
    input  logic [5:0]                priority_req,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    output logic                      status,
    output logic                      running_valid,
    output logic [4:0]                running_task,
    output logic                      switched,
    output logic [4:0]                task_priority,
    output logic [9:0]                task_slice,
    output logic [31:0]               ctx_switch_count
);
    import ptsa_pkg::*;

    function automatic logic [9:0] slice_for(input logic [7:0] base,
                                             input logic [3:0] step,
                                             input logic [LV_W-1:0] prio);
        logic [10:0] s;
        s = 11'(base) + 11'(step) * 11'(prio);
        return (s > SLICE_MAX) ? 10'(SLICE_MAX) : s[9:0];
    endfunction

    logic              slot_used_reg   [TASK_SLOTS];
    logic              is_blocked_reg  [TASK_SLOTS];
    logic [LV_W-1:0]   cur_prio_reg    [TASK_SLOTS];
    logic [LV_W-1:0]   base_prio_reg   [TASK_SLOTS];
    logic [15:0]       wait_age_reg    [TASK_SLOTS];
    logic [9:0]        slice_len_reg   [TASK_SLOTS];
    logic [9:0]        slice_left_reg  [TASK_SLOTS];
    logic [ID_W-1:0]   link_next_reg   [TASK_SLOTS];
    logic [ID_W-1:0]   link_prev_reg   [TASK_SLOTS];
    logic [ID_W-1:0]   level_head_reg  [PRIORITY_LEVELS];
    logic [ID_W-1:0]   level_tail_reg  [PRIORITY_LEVELS];
    logic [CNT_W-1:0]  level_count_reg [PRIORITY_LEVELS];

    logic [15:0] aging_period_reg, aging_period_next;
    logic [15:0] age_limit_reg, age_limit_next;
    logic [4:0]  aging_boost_reg, aging_boost_next;
    logic [7:0]  slice_base_reg, slice_base_next;
    logic [3:0]  slice_step_reg, slice_step_next;

    logic [3:0]       mode_reg, mode_next;
    logic [5:0]       req_reg, req_next;
    logic             id_ok_reg, id_ok_next;
    logic [ID_W-1:0]  tid_reg, tid_next;
    logic [LV_W-1:0]  lv_reg, lv_next;
    logic [LV_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  nx_reg, nx_next;
    logic             was_valid_reg, was_valid_next;
    logic [ID_W-1:0]  was_slot_reg, was_slot_next;
    logic             status_reg, status_next;
    logic [LV_W-1:0]  qprio_reg, qprio_next;
    logic [9:0]       qslice_reg, qslice_next;
    logic             run_valid_reg, run_valid_next;
    logic [ID_W-1:0]  run_slot_reg, run_slot_next;
    logic [15:0]      timer_reg, timer_next;
    logic [31:0]      switch_reg, switch_next;

    logic             used_we, used_d, blk_we, blk_d;
    logic             cur_we, base_we, age_we, slen_we;
    logic [LV_W-1:0]  cur_d, base_d;
    logic [15:0]      age_d;
    logic [9:0]       slen_d;
    logic             sleft_we;
    logic [ID_W-1:0]  sleft_addr;
    logic [9:0]       sleft_d;
    logic             nxt_we, prv_we;
    logic [ID_W-1:0]  nxt_addr, nxt_d, prv_addr, prv_d;
    logic             head_we, tail_we, lcnt_we;
    logic [ID_W-1:0]  head_d, tail_d;
    logic [CNT_W-1:0] lcnt_d;

    logic [CNT_W-1:0] cnt_lv;
    logic [ID_W-1:0]  head_lv, tail_lv, nx_t, pv_t;
    logic [LV_W-1:0]  cur_t, base_t;
    logic [15:0]      age_t, age_inc;
    logic [9:0]       slen_t, sleft_run;
    logic [15:0]      timer_inc;
    logic             running;
    logic [4:0]       boost_eff;
    logic [6:0]       up_sum;
    logic [LV_W-1:0]  up_lv, add_lv, req_lv;
    logic             addressed;

    assign cnt_lv    = level_count_reg[lv_reg];
    assign head_lv   = level_head_reg[lv_reg];
    assign tail_lv   = level_tail_reg[lv_reg];
    assign nx_t      = link_next_reg[tid_reg];
    assign pv_t      = link_prev_reg[tid_reg];
    assign cur_t     = cur_prio_reg[tid_reg];
    assign base_t    = base_prio_reg[tid_reg];
    assign age_t     = wait_age_reg[tid_reg];
    assign slen_t    = slice_len_reg[tid_reg];
    assign sleft_run = slice_left_reg[run_slot_reg];

    assign age_inc   = (age_t == 16'hFFFF) ? age_t : age_t + 16'd1;
    assign timer_inc = timer_reg + 16'd1;
    assign running   = run_valid_reg && (run_slot_reg == tid_reg);
    assign boost_eff = (aging_boost_reg == 5'd0) ? 5'd1 : aging_boost_reg;
    assign up_sum    = 7'(scan_reg) + 7'(boost_eff);
    assign up_lv     = (up_sum > 7'(TOP_LEVEL)) ? TOP_LEVEL : LV_W'(up_sum);
    assign req_lv    = LV_W'(req_reg);
    assign add_lv    = (req_reg > 6'(TOP_LEVEL)) ? DEFAULT_LEVEL : req_lv;
    assign addressed = (mode_reg <= MODE_SETPRIO) || (mode_reg == MODE_QUERY);

    always_comb
    begin
        stat.bad         = (mode_reg > MODE_QUERY) || (addressed && !id_ok_reg);
        stat.mode        = mode_reg;
        stat.used        = slot_used_reg[tid_reg];
        stat.blocked     = is_blocked_reg[tid_reg];
        stat.running     = running;
        stat.req_high    = req_reg > 6'(TOP_LEVEL);
        stat.run_valid   = run_valid_reg;
        stat.slice_zero  = sleft_run == 10'd0;
        stat.age_due     = timer_inc >= aging_period_reg;
        stat.lv_nonempty = cnt_lv != '0;
        stat.lv_is_zero  = lv_reg == '0;
        stat.scan_last   = scan_reg == TOP_LEVEL - LV_W'(1);
        stat.cnt_zero    = cnt_reg == '0;
        stat.age_hit     = age_inc >= age_limit_reg;
    end

    always_comb
    begin
        used_we = 1'b0;  used_d = 1'b0;
        blk_we = 1'b0;   blk_d = 1'b0;
        cur_we = 1'b0;   cur_d = cur_t;
        base_we = 1'b0;  base_d = base_t;
        age_we = 1'b0;   age_d = 16'd0;
        slen_we = 1'b0;  slen_d = slen_t;
        sleft_we = 1'b0; sleft_addr = run_slot_reg; sleft_d = sleft_run;
        nxt_we = 1'b0;   nxt_addr = tail_lv; nxt_d = tid_reg;
        prv_we = 1'b0;   prv_addr = tid_reg; prv_d = tail_lv;
        head_we = 1'b0;  head_d = tid_reg;
        tail_we = 1'b0;  tail_d = tid_reg;
        lcnt_we = 1'b0;  lcnt_d = cnt_lv;

        mode_next      = mode_reg;
        req_next       = req_reg;
        id_ok_next     = id_ok_reg;
        tid_next       = tid_reg;
        lv_next        = lv_reg;
        scan_next      = scan_reg;
        cnt_next       = cnt_reg;
        nx_next        = nx_reg;
        was_valid_next = was_valid_reg;
        was_slot_next  = was_slot_reg;
        status_next    = status_reg;
        qprio_next     = qprio_reg;
        qslice_next    = qslice_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        timer_next     = timer_reg;
        switch_next    = switch_reg;

        case (cmd.op)
            DP_LATCH:
            begin
                mode_next      = mode;
                req_next       = priority_req;
                id_ok_next     = 32'(task_id) < TASK_SLOTS;
                tid_next       = ID_W'(task_id);
                was_valid_next = run_valid_reg;
                was_slot_next  = run_slot_reg;
                status_next    = 1'b0;
                qprio_next     = '0;
                qslice_next    = 10'd0;
            end
            DP_FAIL:
            begin
                status_next = 1'b1;
            end
            DP_ADD:
            begin
                used_we  = 1'b1; used_d = 1'b1;
                blk_we   = 1'b1; blk_d = 1'b0;
                cur_we   = 1'b1; cur_d = add_lv;
                base_we  = 1'b1; base_d = add_lv;
                age_we   = 1'b1;
                slen_we  = 1'b1;
                slen_d   = slice_for(slice_base_reg, slice_step_reg, add_lv);
                sleft_we = 1'b1; sleft_addr = tid_reg; sleft_d = slen_d;
                lv_next  = add_lv;
            end
            DP_PUSH:
            begin
                if (cnt_lv == '0)
                begin
                    head_we = 1'b1;
                end
                else
                begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                end
                tail_we = 1'b1;
                lcnt_we = 1'b1;
                lcnt_d  = cnt_lv + CNT_W'(1);
            end
            DP_UNLINK:
            begin
                if (cnt_lv != '0)
                begin
                    if (head_lv == tid_reg)
                    begin
                        head_we = 1'b1; head_d = nx_t;
                    end
                    else
                    begin
                        nxt_we = 1'b1; nxt_addr = pv_t; nxt_d = nx_t;
                    end
                    if (tail_lv == tid_reg)
                    begin
                        tail_we = 1'b1; tail_d = pv_t;
                    end
                    else
                    begin
                        prv_we = 1'b1; prv_addr = nx_t; prv_d = pv_t;
                    end
                    lcnt_we = 1'b1;
                    lcnt_d  = cnt_lv - CNT_W'(1);
                end
            end
            DP_LV_CUR:
            begin
                lv_next = cur_t;
            end
            DP_SEL_RUN:
            begin
                tid_next = run_slot_reg;
            end
            DP_REMOVE:
            begin
                used_we = 1'b1; used_d = 1'b0;
                blk_we  = 1'b1; blk_d = 1'b0;
                if (running)
                begin
                    run_valid_next = 1'b0;
                end
            end
            DP_BLOCK:
            begin
                blk_we = 1'b1; blk_d = 1'b1;
                if (running)
                begin
                    run_valid_next = 1'b0;
                end
            end
            DP_UNBLOCK:
            begin
                blk_we  = 1'b1; blk_d = 1'b0;
                cur_we  = 1'b1; cur_d = base_t;
                age_we  = 1'b1;
                lv_next = base_t;
            end
            DP_SETPRIO:
            begin
                cur_we  = 1'b1; cur_d = req_lv;
                base_we = 1'b1; base_d = req_lv;
                slen_we = 1'b1;
                slen_d  = slice_for(slice_base_reg, slice_step_reg, req_lv);
                lv_next = req_lv;
            end
            DP_QUERY:
            begin
                qprio_next  = cur_t;
                qslice_next = slen_t;
            end
            DP_TICK:
            begin
                if (run_valid_reg && sleft_run != 10'd0)
                begin
                    sleft_we = 1'b1;
                    sleft_d  = sleft_run - 10'd1;
                end
            end
            DP_TIMER:
            begin
                timer_next = (timer_inc >= aging_period_reg) ? 16'd0 : timer_inc;
            end
            DP_SCAN_TOP:
            begin
                lv_next = TOP_LEVEL;
            end
            DP_SCAN_DOWN:
            begin
                lv_next = lv_reg - LV_W'(1);
            end
            DP_PICK:
            begin
                tid_next = head_lv;
            end
            DP_RUN:
            begin
                if (!running)
                begin
                    switch_next = switch_reg + 32'd1;
                end
                run_valid_next = 1'b1;
                run_slot_next  = tid_reg;
                sleft_we       = 1'b1;
                sleft_addr     = tid_reg;
                sleft_d        = slen_t;
                age_we         = 1'b1;
            end
            DP_AGE_INIT:
            begin
                scan_next = '0;
                lv_next   = '0;
            end
            DP_LVL_LOAD:
            begin
                cnt_next = cnt_lv;
                tid_next = head_lv;
            end
            DP_LVL_NEXT:
            begin
                scan_next = scan_reg + LV_W'(1);
                lv_next   = scan_reg + LV_W'(1);
            end
            DP_VISIT:
            begin
                age_we   = 1'b1;
                age_d    = age_inc;
                nx_next  = nx_t;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            DP_SET_UP:
            begin
                cur_we  = 1'b1; cur_d = up_lv;
                age_we  = 1'b1;
                lv_next = up_lv;
            end
            DP_ADV:
            begin
                tid_next = nx_reg;
                lv_next  = scan_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        aging_period_next = aging_period_reg;
        age_limit_next    = age_limit_reg;
        aging_boost_next  = aging_boost_reg;
        slice_base_next   = slice_base_reg;
        slice_step_next   = slice_step_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_AGING_PERIOD: aging_period_next = cfg_data;
                CFG_AGE_LIMIT:    age_limit_next    = cfg_data;
                CFG_AGING_BOOST:  aging_boost_next  = cfg_data[4:0];
                CFG_SLICE_BASE:   slice_base_next   = cfg_data[7:0];
                CFG_SLICE_STEP:   slice_step_next   = cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_period_reg <= 16'd100;
            age_limit_reg    <= 16'd100;
            aging_boost_reg  <= 5'd1;
            slice_base_reg   <= 8'd10;
            slice_step_reg   <= 4'd2;
            run_valid_reg    <= 1'b0;
            run_slot_reg     <= '0;
            timer_reg        <= 16'd0;
            switch_reg       <= 32'd0;
            mode_reg         <= 4'd0;
            status_reg       <= 1'b0;
            was_valid_reg    <= 1'b0;
            was_slot_reg     <= '0;
            qprio_reg        <= '0;
            qslice_reg       <= 10'd0;
        end
        else
        begin
            aging_period_reg <= aging_period_next;
            age_limit_reg    <= age_limit_next;
            aging_boost_reg  <= aging_boost_next;
            slice_base_reg   <= slice_base_next;
            slice_step_reg   <= slice_step_next;
            run_valid_reg    <= run_valid_next;
            run_slot_reg     <= run_slot_next;
            timer_reg        <= timer_next;
            switch_reg       <= switch_next;
            mode_reg         <= mode_next;
            status_reg       <= status_next;
            was_valid_reg    <= was_valid_next;
            was_slot_reg     <= was_slot_next;
            qprio_reg        <= qprio_next;
            qslice_reg       <= qslice_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        id_ok_reg <= id_ok_next;
        tid_reg   <= tid_next;
        lv_reg    <= lv_next;
        scan_reg  <= scan_next;
        cnt_reg   <= cnt_next;
        nx_reg    <= nx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                slot_used_reg[i]  <= 1'b0;
                is_blocked_reg[i] <= 1'b0;
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                level_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (used_we)
            begin
                slot_used_reg[tid_reg] <= used_d;
            end
            if (blk_we)
            begin
                is_blocked_reg[tid_reg] <= blk_d;
            end
            if (lcnt_we)
            begin
                level_count_reg[lv_reg] <= lcnt_d;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_prio_reg[tid_reg] <= cur_d;
        end
        if (base_we)
        begin
            base_prio_reg[tid_reg] <= base_d;
        end
        if (age_we)
        begin
            wait_age_reg[tid_reg] <= age_d;
        end
        if (slen_we)
        begin
            slice_len_reg[tid_reg] <= slen_d;
        end
        if (sleft_we)
        begin
            slice_left_reg[sleft_addr] <= sleft_d;
        end
        if (nxt_we)
        begin
            link_next_reg[nxt_addr] <= nxt_d;
        end
        if (prv_we)
        begin
            link_prev_reg[prv_addr] <= prv_d;
        end
        if (head_we)
        begin
            level_head_reg[lv_reg] <= head_d;
        end
        if (tail_we)
        begin
            level_tail_reg[lv_reg] <= tail_d;
        end
    end

    assign status           = status_reg;
    assign running_valid    = run_valid_reg;
    assign running_task     = run_valid_reg ? 5'(run_slot_reg) : 5'd0;
    assign switched         = (was_valid_reg != run_valid_reg)
                              || (run_valid_reg && (was_slot_reg != run_slot_reg));
    assign task_priority    = 5'(qprio_reg);
    assign task_slice       = qslice_reg;
    assign ctx_switch_count = switch_reg;

endmodule

// ===== rtl/ptsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsa_ctrl: event sequencer of the aging priority task scheduler
// Decodes each event and steps the datapath through list operations, the
// level search of a schedule and the aging pass.
// ----------------------------------------------------------------------------
module ptsa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ptsa_pkg::dp_stat_t   stat,
    output ptsa_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import ptsa_pkg::*;

    ctl_state_t state_reg, state_next;
    ctl_state_t sched_ret;

    assign sched_ret = (stat.mode == MODE_TICK) ? ST_TIMER : ST_DONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.bad)
                begin
                    cmd.op     = DP_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.mode)
                        MODE_ADD:
                        begin
                            if (stat.used)
                            begin
                                cmd.op     = DP_FAIL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cmd.op     = DP_ADD;
                                state_next = ST_PUSH_FIN;
                            end
                        end
                        MODE_SCHED, MODE_YIELD:
                        begin
                            state_next = ST_SCH_REQ;
                        end
                        MODE_TICK:
                        begin
                            cmd.op     = DP_TICK;
                            state_next = ST_TICK_CHK;
                        end
                        default:
                        begin
                            if (!stat.used)
                            begin
                                cmd.op     = DP_FAIL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                case (stat.mode)
                                    MODE_REMOVE:
                                    begin
                                        cmd.op     = DP_LV_CUR;
                                        state_next = ST_RM;
                                    end
                                    MODE_BLOCK:
                                    begin
                                        if (stat.blocked)
                                        begin
                                            cmd.op     = DP_FAIL;
                                            state_next = ST_DONE;
                                        end
                                        else
                                        begin
                                            cmd.op     = DP_LV_CUR;
                                            state_next = ST_BLK;
                                        end
                                    end
                                    MODE_UNBLOCK:
                                    begin
                                        if (!stat.blocked)
                                        begin
                                            cmd.op     = DP_FAIL;
                                            state_next = ST_DONE;
                                        end
                                        else
                                        begin
                                            cmd.op     = DP_UNBLOCK;
                                            state_next = ST_PUSH_FIN;
                                        end
                                    end
                                    MODE_SETPRIO:
                                    begin
                                        if (stat.req_high)
                                        begin
                                            cmd.op     = DP_FAIL;
                                            state_next = ST_DONE;
                                        end
                                        else
                                        begin
                                            cmd.op     = DP_LV_CUR;
                                            state_next = ST_SET_UL;
                                        end
                                    end
                                    default:
                                    begin
                                        cmd.op     = DP_QUERY;
                                        state_next = ST_DONE;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            ST_PUSH_FIN:
            begin
                cmd.op     = DP_PUSH;
                state_next = ST_DONE;
            end
            ST_RM:
            begin
                if (!stat.running && !stat.blocked)
                begin
                    cmd.op = DP_UNLINK;
                end
                state_next = ST_RM_FIN;
            end
            ST_RM_FIN:
            begin
                cmd.op     = DP_REMOVE;
                state_next = ST_DONE;
            end
            ST_BLK:
            begin
                if (!stat.running)
                begin
                    cmd.op = DP_UNLINK;
                end
                state_next = ST_BLK_FIN;
            end
            ST_BLK_FIN:
            begin
                cmd.op     = DP_BLOCK;
                state_next = stat.running ? ST_SCH_REQ : ST_DONE;
            end
            ST_SET_UL:
            begin
                if (!stat.running && !stat.blocked)
                begin
                    cmd.op = DP_UNLINK;
                end
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                cmd.op     = DP_SETPRIO;
                state_next = (!stat.running && !stat.blocked) ? ST_PUSH_FIN : ST_DONE;
            end
            ST_SCH_REQ:
            begin
                if (stat.run_valid)
                begin
                    cmd.op     = DP_SEL_RUN;
                    state_next = ST_SCH_LV;
                end
                else
                begin
                    state_next = ST_SCH_TOP;
                end
            end
            ST_SCH_LV:
            begin
                cmd.op     = DP_LV_CUR;
                state_next = ST_SCH_PUSH;
            end
            ST_SCH_PUSH:
            begin
                cmd.op     = DP_PUSH;
                state_next = ST_SCH_TOP;
            end
            ST_SCH_TOP:
            begin
                cmd.op     = DP_SCAN_TOP;
                state_next = ST_SCH_SCAN;
            end
            ST_SCH_SCAN:
            begin
                if (stat.lv_nonempty)
                begin
                    cmd.op     = DP_PICK;
                    state_next = ST_SCH_UL;
                end
                else if (stat.lv_is_zero)
                begin
                    state_next = sched_ret;
                end
                else
                begin
                    cmd.op = DP_SCAN_DOWN;
                end
            end
            ST_SCH_UL:
            begin
                cmd.op     = DP_UNLINK;
                state_next = ST_SCH_RUN;
            end
            ST_SCH_RUN:
            begin
                cmd.op     = DP_RUN;
                state_next = sched_ret;
            end
            ST_TICK_CHK:
            begin
                state_next = (stat.run_valid && stat.slice_zero) ? ST_SCH_REQ : ST_TIMER;
            end
            ST_TIMER:
            begin
                cmd.op     = DP_TIMER;
                state_next = stat.age_due ? ST_AGE_START : ST_DONE;
            end
            ST_AGE_START:
            begin
                cmd.op     = DP_AGE_INIT;
                state_next = ST_AGE_LVL;
            end
            ST_AGE_LVL:
            begin
                cmd.op     = DP_LVL_LOAD;
                state_next = ST_AGE_CHK;
            end
            ST_AGE_CHK:
            begin
                if (stat.cnt_zero)
                begin
                    if (stat.scan_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.op     = DP_LVL_NEXT;
                        state_next = ST_AGE_LVL;
                    end
                end
                else
                begin
                    cmd.op     = DP_VISIT;
                    state_next = stat.age_hit ? ST_AGE_UL : ST_AGE_ADV;
                end
            end
            ST_AGE_UL:
            begin
                cmd.op     = DP_UNLINK;
                state_next = ST_AGE_UP;
            end
            ST_AGE_UP:
            begin
                cmd.op     = DP_SET_UP;
                state_next = ST_AGE_PUSH;
            end
            ST_AGE_PUSH:
            begin
                cmd.op     = DP_PUSH;
                state_next = ST_AGE_ADV;
            end
            ST_AGE_ADV:
            begin
                cmd.op     = DP_ADV;
                state_next = ST_AGE_CHK;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;
    assign done = state_reg == ST_DONE;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("Accepted transaction did not enter decode.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("Controller did not return to idle after a result.");

endmodule
